// ===== design/utld_pkg.sv =====
// utld_pkg: shared types, widths and reciprocal constants for the
// timestamp-to-local-date converter. No dependencies.
`default_nettype none
package utld_pkg;

  localparam int unsigned TsW     = 32;
  localparam int unsigned OffW    = 5;
  localparam int unsigned LocSecW = 33;  // local seconds plus one day, never negative
  localparam int unsigned DaysW   = 16;
  localparam int unsigned SodW    = 17;
  localparam int unsigned DoeW    = 18;
  localparam int unsigned YoeW    = 9;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;

  localparam int unsigned SecPerDay   = 86400;
  localparam int unsigned SecPerHour  = 3600;
  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned DayShiftLo  = 7;     // 86400 = 128 * 675
  localparam int unsigned DayOdd      = 675;
  localparam int unsigned EpochShiftM1 = 719467;
  localparam int unsigned EraFourStart = 584388;  // 4 * 146097
  localparam int unsigned EraFiveStart = 730485;  // 5 * 146097
  localparam int unsigned DaysPer100  = 36524;
  localparam int unsigned DaysPer400m1 = 146096;

  // ceil(2^k / d) reciprocals, exact over the operand ranges used
  localparam int unsigned DayK   = 36;
  localparam logic [26:0] DayRecip = 27'(((64'd1 << DayK) + 64'd674) / 64'd675);
  localparam int unsigned K1460  = 29;
  localparam logic [18:0] Recip1460 = 19'(((64'd1 << K1460) + 64'd1459) / 64'd1460);
  localparam int unsigned K3600  = 29;
  localparam logic [17:0] Recip3600 = 18'(((64'd1 << K3600) + 64'd3599) / 64'd3600);
  localparam int unsigned K365   = 27;
  localparam logic [18:0] Recip365 = 19'(((64'd1 << K365) + 64'd364) / 64'd365);
  localparam int unsigned K60    = 18;
  localparam logic [12:0] Recip60 = 13'(((64'd1 << K60) + 64'd59) / 64'd60);
  localparam int unsigned K153   = 19;
  localparam logic [11:0] Recip153 = 12'(((64'd1 << K153) + 64'd152) / 64'd153);

  typedef struct packed {
    logic full;
    logic empty;
  } utld_qstat_t;

  // first day of each month, counted from 1 March
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] mp);
    logic [DoyW-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/utld_front.sv =====
// utld_front: takes a word, applies the zone offset and forms local seconds.
// Depends on utld_pkg.
`default_nettype none
module utld_front import utld_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [TsW-1:0]     timestamp_i,
  input  wire logic [OffW-1:0]    tz_offset_hours_i,
  input  wire utld_qstat_t        qstat_i,
  output logic                    busy_o,
  output logic                    push_o,
  output logic [LocSecW-1:0]      loc_sec_o
);

  logic                     valid_q, valid_d;
  logic [LocSecW-1:0]       loc_sec_q;
  logic signed [17:0]       off_sec;
  logic [LocSecW-1:0]       loc_sec_d;
  logic                     accept;

  assign off_sec   = $signed(tz_offset_hours_i) * 18'sd3600;
  assign loc_sec_d = LocSecW'(timestamp_i) + LocSecW'(SecPerDay)
                   + {{(LocSecW-18){off_sec[17]}}, off_sec};

  assign busy_o  = valid_q & qstat_i.full;
  assign accept  = start_i & ~busy_o;
  assign push_o  = valid_q & ~qstat_i.full;
  assign valid_d = accept | (valid_q & ~push_o);
  assign loc_sec_o = loc_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      loc_sec_q <= loc_sec_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/utld_fifo.sv =====
// utld_fifo: two-word queue between front and back.
// Depends on utld_pkg.
`default_nettype none
module utld_fifo import utld_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [LocSecW-1:0] wdata_i,
  input  wire logic               pop_i,
  output logic [LocSecW-1:0]      rdata_o,
  output utld_qstat_t             qstat_o
);

  logic [LocSecW-1:0] mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);
  assign rdata_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/utld_back.sv =====
// utld_back: eight-stage pipeline from local seconds to date and time of day.
// Depends on utld_pkg.
`default_nettype none
module utld_back import utld_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire utld_qstat_t        qstat_i,
  input  wire logic [LocSecW-1:0] loc_sec_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic [YearW-1:0]        year_o,
  output logic [MonthW-1:0]       month_o,
  output logic [DayW-1:0]         day_o,
  output logic [HourW-1:0]        hour_o,
  output logic [MinW-1:0]         minute_o,
  output logic [SecW-1:0]         second_o
);

  localparam int unsigned XW = LocSecW - DayShiftLo;

  logic [7:0] vld_q, vld_d;

  // stage 1: days = (sec >> 7) / 675
  logic [XW-1:0]         s1_x_q;
  logic [DayShiftLo-1:0] s1_lo_q;
  logic [DaysW-1:0]      s1_days_q;
  logic [52:0]           day_prod;

  // stage 2: second of day, day of era
  logic [SodW-1:0]  s2_sod_q;
  logic [DoeW-1:0]  s2_doe_q;
  logic             s2_era5_q;
  logic [XW-1:0]    rem675;
  logic [19:0]      z;
  logic             era5;

  // stage 3: doe/1460, doe/36524, doe/146096, hour
  logic [SodW-1:0]  s3_sod_q;
  logic [DoeW-1:0]  s3_doe_q;
  logic             s3_era5_q;
  logic [6:0]       s3_a_q;
  logic [2:0]       s3_b_q;
  logic             s3_c_q;
  logic [HourW-1:0] s3_hour_q;
  logic [36:0]      a_prod;
  logic [34:0]      hour_prod;
  logic [2:0]       b_d;

  // stage 4
  logic [DoeW-1:0]  s4_n_q;
  logic [DoeW-1:0]  s4_doe_q;
  logic             s4_era5_q;
  logic [11:0]      s4_rs_q;
  logic [HourW-1:0] s4_hour_q;
  logic [SodW-1:0]  rs_full;

  // stage 5
  logic [YoeW-1:0]  s5_yoe_q;
  logic [DoeW-1:0]  s5_doe_q;
  logic             s5_era5_q;
  logic [11:0]      s5_rs_q;
  logic [HourW-1:0] s5_hour_q;
  logic [MinW-1:0]  s5_min_q;
  logic [36:0]      yoe_prod;
  logic [24:0]      min_prod;

  // stage 6
  logic [DoyW-1:0]  s6_doy_q;
  logic [YearW-1:0] s6_ybase_q;
  logic [HourW-1:0] s6_hour_q;
  logic [MinW-1:0]  s6_min_q;
  logic [SecW-1:0]  s6_sec_q;
  logic [1:0]       yh;
  logic [DoeW-1:0]  ystart;
  logic [DoeW-1:0]  doy_full;
  logic [11:0]      sec_full;

  // stage 7
  logic [MonthW-1:0] s7_mp_q;
  logic [DoyW-1:0]   s7_doy_q;
  logic [YearW-1:0]  s7_ybase_q;
  logic [HourW-1:0]  s7_hour_q;
  logic [MinW-1:0]   s7_min_q;
  logic [SecW-1:0]   s7_sec_q;
  logic [10:0]       t153;
  logic [22:0]       mp_prod;

  // stage 8
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;
  logic [HourW-1:0]  hour_q;
  logic [MinW-1:0]   min_q;
  logic [SecW-1:0]   sec_q;
  logic [MonthW-1:0] month_d;
  logic [DoyW-1:0]   day_full;

  assign pop_o = ~qstat_i.empty;
  assign vld_d = {vld_q[6:0], pop_o};

  assign day_prod = 53'(loc_sec_i[LocSecW-1:DayShiftLo]) * 53'(DayRecip);

  assign rem675 = s1_x_q - XW'(s1_days_q) * XW'(DayOdd);
  assign z      = 20'(s1_days_q) + 20'(EpochShiftM1);
  assign era5   = (z >= 20'(EraFiveStart));

  assign a_prod    = 37'(s2_doe_q) * 37'(Recip1460);
  assign hour_prod = 35'(s2_sod_q) * 35'(Recip3600);

  always_comb begin
    if (s2_doe_q >= DoeW'(4 * DaysPer100)) begin
      b_d = 3'd4;
    end else if (s2_doe_q >= DoeW'(3 * DaysPer100)) begin
      b_d = 3'd3;
    end else if (s2_doe_q >= DoeW'(2 * DaysPer100)) begin
      b_d = 3'd2;
    end else if (s2_doe_q >= DoeW'(DaysPer100)) begin
      b_d = 3'd1;
    end else begin
      b_d = 3'd0;
    end
  end

  assign rs_full = s3_sod_q - SodW'(s3_hour_q) * SodW'(SecPerHour);

  assign yoe_prod = 37'(s4_n_q) * 37'(Recip365);
  assign min_prod = 25'(s4_rs_q) * 25'(Recip60);

  always_comb begin
    if (s5_yoe_q >= YoeW'(300)) begin
      yh = 2'd3;
    end else if (s5_yoe_q >= YoeW'(200)) begin
      yh = 2'd2;
    end else if (s5_yoe_q >= YoeW'(100)) begin
      yh = 2'd1;
    end else begin
      yh = 2'd0;
    end
  end

  assign ystart   = DoeW'(s5_yoe_q) * DoeW'(365) + DoeW'(s5_yoe_q >> 2) - DoeW'(yh);
  assign doy_full = s5_doe_q - ystart;
  assign sec_full = s5_rs_q - 12'(s5_min_q) * 12'(SecPerMin);

  assign t153    = 11'({s6_doy_q, 2'b00}) + 11'(s6_doy_q) + 11'd2;
  assign mp_prod = 23'(t153) * 23'(Recip153);

  assign month_d  = (s7_mp_q < 4'd10) ? s7_mp_q + 4'd3 : s7_mp_q - 4'd9;
  assign day_full = s7_doy_q - month_start(s7_mp_q) + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q    <= loc_sec_i[LocSecW-1:DayShiftLo];
    s1_lo_q   <= loc_sec_i[DayShiftLo-1:0];
    s1_days_q <= day_prod[DayK +: DaysW];

    s2_sod_q  <= {rem675[9:0], s1_lo_q};
    s2_doe_q  <= DoeW'(z - (era5 ? 20'(EraFiveStart) : 20'(EraFourStart)));
    s2_era5_q <= era5;

    s3_sod_q  <= s2_sod_q;
    s3_doe_q  <= s2_doe_q;
    s3_era5_q <= s2_era5_q;
    s3_a_q    <= a_prod[K1460 +: 7];
    s3_b_q    <= b_d;
    s3_c_q    <= (s2_doe_q == DoeW'(DaysPer400m1));
    s3_hour_q <= hour_prod[K3600 +: HourW];

    s4_n_q    <= s3_doe_q - DoeW'(s3_a_q) + DoeW'(s3_b_q) - DoeW'(s3_c_q);
    s4_doe_q  <= s3_doe_q;
    s4_era5_q <= s3_era5_q;
    s4_rs_q   <= rs_full[11:0];
    s4_hour_q <= s3_hour_q;

    s5_yoe_q  <= yoe_prod[K365 +: YoeW];
    s5_doe_q  <= s4_doe_q;
    s5_era5_q <= s4_era5_q;
    s5_rs_q   <= s4_rs_q;
    s5_hour_q <= s4_hour_q;
    s5_min_q  <= min_prod[K60 +: MinW];

    s6_doy_q   <= doy_full[DoyW-1:0];
    s6_ybase_q <= YearW'(s5_yoe_q) + (s5_era5_q ? 12'd2000 : 12'd1600);
    s6_hour_q  <= s5_hour_q;
    s6_min_q   <= s5_min_q;
    s6_sec_q   <= sec_full[SecW-1:0];

    s7_mp_q    <= mp_prod[K153 +: MonthW];
    s7_doy_q   <= s6_doy_q;
    s7_ybase_q <= s6_ybase_q;
    s7_hour_q  <= s6_hour_q;
    s7_min_q   <= s6_min_q;
    s7_sec_q   <= s6_sec_q;

    year_q  <= s7_ybase_q + YearW'(month_d <= 4'd2);
    month_q <= month_d;
    day_q   <= day_full[DayW-1:0];
    hour_q  <= s7_hour_q;
    min_q   <= s7_min_q;
    sec_q   <= s7_sec_q;
  end

  assign done_o   = vld_q[7];
  assign year_o   = year_q;
  assign month_o  = month_q;
  assign day_o    = day_q;
  assign hour_o   = hour_q;
  assign minute_o = min_q;
  assign second_o = sec_q;

endmodule
`default_nettype wire

// ===== design/unix_time_to_local_datetime.sv =====
// Unix timestamp plus whole-hour zone offset to local Gregorian date and time.
// Throughput: one word per cycle while busy is low. Each accepted word passes the
// front register, the queue and the eight-stage date pipeline before done_o rises.
// Reset (async, active low) empties the front register, queue and pipeline.
// Depends on utld_pkg, utld_front, utld_fifo, utld_back.
`default_nettype none
module unix_time_to_local_datetime import utld_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [TsW-1:0]    timestamp_i,
  input  wire logic [OffW-1:0]   tz_offset_hours_i,
  output logic                   done_o,
  output logic [YearW-1:0]       year_o,
  output logic [MonthW-1:0]      month_o,
  output logic [DayW-1:0]        day_o,
  output logic [HourW-1:0]       hour_o,
  output logic [MinW-1:0]        minute_o,
  output logic [SecW-1:0]        second_o
);

  utld_qstat_t        qstat;
  logic               push, pop;
  logic [LocSecW-1:0] wdata, rdata;

  utld_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .timestamp_i       (timestamp_i),
    .tz_offset_hours_i (tz_offset_hours_i),
    .qstat_i           (qstat),
    .busy_o            (busy),
    .push_o            (push),
    .loc_sec_o         (wdata)
  );

  utld_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .rdata_o (rdata),
    .qstat_o (qstat)
  );

  utld_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qstat_i   (qstat),
    .loc_sec_i (rdata),
    .pop_o     (pop),
    .done_o    (done_o),
    .year_o    (year_o),
    .month_o   (month_o),
    .day_o     (day_o),
    .hour_o    (hour_o),
    .minute_o  (minute_o),
    .second_o  (second_o)
  );

endmodule
`default_nettype wire

// ===== design/utld_checker.sv =====
// utld_checker: port-level checks on the converter, bound to the top level.
// Depends on utld_pkg.
`default_nettype none
module utld_checker import utld_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [TsW-1:0]    timestamp_i,
  input wire logic [OffW-1:0]   tz_offset_hours_i,
  input wire logic              done_o,
  input wire logic [YearW-1:0]  year_o,
  input wire logic [MonthW-1:0] month_o,
  input wire logic [DayW-1:0]   day_o,
  input wire logic [HourW-1:0]  hour_o,
  input wire logic [MinW-1:0]   minute_o,
  input wire logic [SecW-1:0]   second_o
);

  // every accepted word must come out with a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##10 done_o)
    else $error("accepted word did not complete on time");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 10))
    else $error("result strobe without an accepted word");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1
                && year_o >= 12'd1969 && year_o <= 12'd2106))
    else $error("date out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59))
    else $error("time of day out of range");

endmodule

bind unix_time_to_local_datetime utld_checker u_chk (.*);
`default_nettype wire
